// File: hdl/gnb_pkg.sv
package gnb_pkg;

  // Default sizing
  localparam int NUM_FEATURES_DEF = 16;
  localparam int NUM_CLASSES_DEF  = 3;

  // Field widths
  localparam int OP_W   = 3;
  localparam int CLS_W  = 2;
  localparam int FEAT_W = 4;
  localparam int COEF_W = 32;
  localparam int X_W    = 16;
  localparam int MEAN_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLASSIFY  = 3'd0;
  localparam logic [OP_W-1:0] OP_LD_MEAN   = 3'd1;
  localparam logic [OP_W-1:0] OP_LD_INV2V  = 3'd2;
  localparam logic [OP_W-1:0] OP_LD_LOGN   = 3'd3;
  localparam logic [OP_W-1:0] OP_LD_PRIOR  = 3'd4;

  // ln(1e-10) in Q16.16
  localparam logic signed [31:0] LOG_FLOOR = -32'sd1509022;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [CLS_W-1:0]         class_index;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [X_W-1:0]    feature_value;
    logic                     last;
  } gnb_in_t;

  typedef struct packed {
    logic [CLS_W-1:0]  predicted_class;
    logic signed [31:0] best_score;
    logic              feature_overflow;
    logic              model_ready;
  } gnb_out_t;

endpackage

// File: hdl/gnb_if.sv
// Request channel carrying one input item
interface gnb_in_if;
  import gnb_pkg::*;
  logic    valid;
  logic    ready;
  gnb_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel carrying one result item
interface gnb_out_if;
  import gnb_pkg::*;
  logic     valid;
  logic     ready;
  gnb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/gaussian_naive_bayes_classifier_unit.sv
// Channel   | Dir | Payload                                              | Handshake
// in_chan   | in  | operation, class_index, feature_index, coefficient,  | valid/ready
//           |     | feature_value, last                                  |
// out_chan  | out | predicted_class, best_score, feature_overflow,       | valid/ready
//           |     | model_ready                                          |
//
// A load, or a classify on an empty model or past the table end, issues no table read;
// other classify features issue one shared RAM read per class, class by class.
// The last feature then drains the pipeline, adds the priors and takes the argmax
// class by class on a loaded model, and hands the result over; no request is taken meanwhile.
// Reset is synchronous; accumulators, counter and flags clear, tables do not.
// A stalled output holds its result while the next sample is taken in.
module gaussian_naive_bayes_classifier_unit #(
  parameter int NUM_FEATURES = gnb_pkg::NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = gnb_pkg::NUM_CLASSES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gnb_in_if.sink           in_chan,
  gnb_out_if.source        out_chan
);
  import gnb_pkg::*;

  localparam int DEPTH = NUM_CLASSES * NUM_FEATURES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int FI_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CNT_W = $clog2(NUM_FEATURES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [CW-1:0]    CLS_LAST  = CW'(NUM_CLASSES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_FEATURES);
  localparam logic signed [48:0] FLOOR_EXT = $signed({{17{LOG_FLOOR[31]}}, LOG_FLOOR});
  localparam logic signed [48:0] TERM_MAX  = 49'sd8589934591;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] != {4{v[34]}}) begin
      r = v[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    iss_cls_r;
  logic [FI_W-1:0]  feat_r;
  logic             pend_last_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             ready_r;
  logic [CW-1:0]    fc_r;
  logic             out_valid_r;
  logic             p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;

  // Payload state
  logic signed [X_W-1:0]  x_r;
  logic signed [X_W-1:0]  p1_x_r;
  logic [CW-1:0]          p1_cls_r, p2_cls_r, p3_cls_r, p4_cls_r;
  logic [31:0]            p2_d2_r;
  logic signed [31:0]     p2_inv_r, p2_logn_r, p3_logn_r;
  logic signed [63:0]     p3_prod_r;
  logic signed [33:0]     p4_term_r;
  logic signed [31:0]     acc_r [NUM_CLASSES];
  logic signed [31:0]     prior_r [NUM_CLASSES];
  logic signed [31:0]     best_r;
  logic [CW-1:0]          best_cls_r;
  gnb_out_t               out_data_r;

  // Request decode
  gnb_in_t req;
  logic    acc_in;
  logic    idx_ok, cls_ok;
  logic    is_cls, feat_room, issue_now, emit_go, pipe_empty;

  assign req       = in_chan.data;
  assign acc_in    = in_chan.valid && in_chan.ready;
  assign cls_ok    = int'(req.class_index) < NUM_CLASSES;
  assign idx_ok    = cls_ok && (int'(req.feature_index) < NUM_FEATURES);
  assign is_cls    = acc_in && (req.operation == OP_CLASSIFY);
  assign feat_room = cnt_r < CNT_FULL;
  assign issue_now = is_cls && feat_room && ready_r;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  assign pipe_empty = !(p1_vld_r || p2_vld_r || p3_vld_r || p4_vld_r);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Coefficient RAMs
  logic [AW-1:0]        waddr, raddr;
  logic [CW-1:0]        rd_cls;
  logic [FI_W-1:0]      rd_feat;
  logic                 we_mean, we_inv, we_logn;
  logic [MEAN_W-1:0]    mean_rd;
  logic [31:0]          inv_rd, logn_rd;

  assign waddr   = AW'(AW'(req.class_index) * AW'(NUM_FEATURES)) + AW'(req.feature_index);
  assign rd_cls  = (state_r == ST_ISSUE) ? iss_cls_r : '0;
  assign rd_feat = (state_r == ST_ISSUE) ? feat_r : cnt_r[FI_W-1:0];
  assign raddr   = AW'(AW'(rd_cls) * AW'(NUM_FEATURES)) + AW'(rd_feat);
  assign we_mean = acc_in && (req.operation == OP_LD_MEAN)  && idx_ok;
  assign we_inv  = acc_in && (req.operation == OP_LD_INV2V) && idx_ok;
  assign we_logn = acc_in && (req.operation == OP_LD_LOGN)  && idx_ok;

  gnb_ram #(.WIDTH(MEAN_W), .DEPTH(DEPTH)) u_mean_ram (
    .clk(clk), .we(we_mean), .waddr(waddr), .wdata(req.coefficient[MEAN_W-1:0]),
    .raddr(raddr), .rdata(mean_rd)
  );

  gnb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_inv_ram (
    .clk(clk), .we(we_inv), .waddr(waddr), .wdata(req.coefficient),
    .raddr(raddr), .rdata(inv_rd)
  );

  gnb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_logn_ram (
    .clk(clk), .we(we_logn), .waddr(waddr), .wdata(req.coefficient),
    .raddr(raddr), .rdata(logn_rd)
  );

  // Datapath: difference and square
  logic signed [16:0] d;
  logic signed [33:0] d2_full;
  assign d       = $signed({p1_x_r[X_W-1], p1_x_r}) - $signed({mean_rd[MEAN_W-1], mean_rd});
  assign d2_full = d * d;

  // Datapath: scale by 1/(2 var)
  logic signed [64:0] prod_full;
  assign prod_full = $signed({1'b0, p2_d2_r}) * p2_inv_r;

  // Datapath: floor to Q16.16, subtract from log norm, floor and clamp the term
  logic signed [47:0] prod_fl;
  logic signed [48:0] term;
  logic signed [33:0] term_cl;
  assign prod_fl = p3_prod_r[63:16];
  assign term    = $signed({{17{p3_logn_r[31]}}, p3_logn_r}) - $signed({prod_fl[47], prod_fl});
  always_comb begin
    if (term < FLOOR_EXT) begin
      term_cl = 34'(FLOOR_EXT);
    end else if (term > TERM_MAX) begin
      term_cl = 34'(TERM_MAX);
    end else begin
      term_cl = term[33:0];
    end
  end

  // Accumulator read: one shared port, final pass or accumulate stage
  logic [CW-1:0]      acc_idx;
  logic signed [31:0] acc_rd;
  logic signed [31:0] acc_sum, fin_sum;
  assign acc_idx = (state_r == ST_FINAL) ? fc_r : p4_cls_r;
  assign acc_rd  = acc_r[acc_idx];
  assign acc_sum = sat32($signed({{3{acc_rd[31]}}, acc_rd}) + $signed({p4_term_r[33], p4_term_r}));
  assign fin_sum = sat32($signed({{3{acc_rd[31]}}, acc_rd})
                         + $signed({{3{prior_r[fc_r][31]}}, prior_r[fc_r]}));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (issue_now) begin
          state_nxt = ST_ISSUE;
        end else if (is_cls && req.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_ISSUE: begin
        if (iss_cls_r == CLS_LAST) begin
          state_nxt = pend_last_r ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ready_r ? ST_FINAL : ST_EMIT;
        end
      end
      ST_FINAL: begin
        if (fc_r == CLS_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_cls_r   <= '0;
      pend_last_r <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      ready_r     <= 1'b0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        acc_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Mark the model loaded on any in-range load
      if (we_mean || we_inv || we_logn ||
          (acc_in && (req.operation == OP_LD_PRIOR) && cls_ok)) begin
        ready_r <= 1'b1;
      end

      // Count features, flag the excess
      if (is_cls) begin
        if (feat_room) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end

      // Advance the class issue counter
      if (issue_now) begin
        iss_cls_r   <= CW'(1);
        pend_last_r <= req.last;
      end else if (state_r == ST_ISSUE) begin
        iss_cls_r <= iss_cls_r + 1'b1;
      end

      // Advance the pipeline valids
      p1_vld_r <= issue_now || (state_r == ST_ISSUE);
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;

      // Final pass counter
      if (state_r == ST_FINAL) begin
        fc_r <= fc_r + 1'b1;
      end else begin
        fc_r <= '0;
      end

      // Accumulate, or drop the sample once its result is handed over
      if (emit_go) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          acc_r[c] <= '0;
        end
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (p4_vld_r) begin
        acc_r[p4_cls_r] <= acc_sum;
      end

      // Output register
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue_now) begin
      x_r    <= req.feature_value;
      feat_r <= cnt_r[FI_W-1:0];
    end
    p1_x_r   <= (state_r == ST_ISSUE) ? x_r : req.feature_value;
    p1_cls_r <= rd_cls;

    p2_cls_r  <= p1_cls_r;
    p2_d2_r   <= d2_full[31:0];
    p2_inv_r  <= $signed(inv_rd);
    p2_logn_r <= $signed(logn_rd);

    p3_cls_r  <= p2_cls_r;
    p3_prod_r <= prod_full[63:0];
    p3_logn_r <= p2_logn_r;

    p4_cls_r  <= p3_cls_r;
    p4_term_r <= term_cl;

    // Hold the log priors
    if (acc_in && (req.operation == OP_LD_PRIOR) && cls_ok) begin
      prior_r[CW'(req.class_index)] <= req.coefficient;
    end

    // Argmax, strict greater keeps the lower class on a tie
    if (state_r == ST_DRAIN) begin
      best_r     <= '0;
      best_cls_r <= '0;
    end else if (state_r == ST_FINAL) begin
      if ((fc_r == '0) || (fin_sum > best_r)) begin
        best_r     <= fin_sum;
        best_cls_r <= fc_r;
      end
    end

    if (emit_go) begin
      out_data_r.predicted_class  <= CLS_W'(best_cls_r);
      out_data_r.best_score       <= best_r;
      out_data_r.feature_overflow <= ovf_r;
      out_data_r.model_ready      <= ready_r;
    end
  end

  // Checks
  a_acc_quiet_in_final : assert property (@(posedge clk) disable iff (!rst_n)
    p4_vld_r |-> (state_r != ST_FINAL) && (state_r != ST_EMIT))
    else $error("accumulate stage active during final pass");

  a_result_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside the emit step");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("feature counter beyond table size");

  a_issue_needs_model : assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> $past(ready_r))
    else $error("coefficient read issued before any load");

endmodule

// File: hdl/gnb_ram.sv
module gnb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/gnb_verdict_monitor.sv
module gnb_verdict_monitor #(
  parameter int NUM_FEATURES = gnb_pkg::NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = gnb_pkg::NUM_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gnb_in_if           in_mon,
  gnb_out_if          out_mon,
  output int unsigned mismatch_total,
  output int unsigned verdicts_pending,
  output int unsigned verdicts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import gnb_pkg::*;

  localparam longint SCORE_MAX = 64'sd2147483647;
  localparam longint SCORE_MIN = -64'sd2147483648;
  localparam int     REPORT_MAX = 10;

  // Coefficient tables as the block should hold them
  bit signed [MEAN_W-1:0] mean_tab    [NUM_CLASSES][NUM_FEATURES];
  bit signed [31:0]       inv2var_tab [NUM_CLASSES][NUM_FEATURES];
  bit signed [31:0]       lognorm_tab [NUM_CLASSES][NUM_FEATURES];
  bit signed [31:0]       prior_tab   [NUM_CLASSES];

  // Per-sample running state
  bit signed [31:0] score_acc [NUM_CLASSES];
  int unsigned      feat_count;
  bit               overflow_seen;
  bit               model_loaded;

  gnb_out_t    expected_verdicts[$];
  int unsigned n_mismatch;
  int unsigned n_checked;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > SCORE_MAX) return 32'sh7FFF_FFFF;
    if (v < SCORE_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // One feature's Gaussian log-likelihood, floored at ln(1e-10)
  function automatic longint gauss_log_term(logic signed [X_W-1:0] x,
                                            logic signed [MEAN_W-1:0] mu,
                                            logic signed [31:0] inv2v,
                                            logic signed [31:0] logn);
    longint diff;
    longint sq;
    longint prod;
    longint term;
    diff = longint'(x) - longint'(mu);
    sq   = diff * diff;
    prod = (sq * longint'(inv2v)) >>> 16;
    term = longint'(logn) - prod;
    if (term < longint'(LOG_FLOOR)) term = longint'(LOG_FLOOR);
    return term;
  endfunction

  function automatic void clear_sample();
    foreach (score_acc[c]) score_acc[c] = '0;
    feat_count    = 0;
    overflow_seen = 1'b0;
  endfunction

  // Advance the prediction by one accepted request
  function automatic void absorb_request(gnb_in_t r);
    gnb_out_t         verdict;
    logic signed [31:0] s;
    logic signed [31:0] top_score;
    int               c;
    case (r.operation)
      OP_LD_MEAN, OP_LD_INV2V, OP_LD_LOGN: begin
        if (r.class_index < NUM_CLASSES && r.feature_index < NUM_FEATURES) begin
          case (r.operation)
            OP_LD_MEAN:  mean_tab[r.class_index][r.feature_index] = r.coefficient[MEAN_W-1:0];
            OP_LD_INV2V: inv2var_tab[r.class_index][r.feature_index] = r.coefficient;
            default:     lognorm_tab[r.class_index][r.feature_index] = r.coefficient;
          endcase
          model_loaded = 1'b1;
        end
      end
      OP_LD_PRIOR: begin
        if (r.class_index < NUM_CLASSES) begin
          prior_tab[r.class_index] = r.coefficient;
          model_loaded = 1'b1;
        end
      end
      OP_CLASSIFY: begin
        // Drop features beyond the table, but remember that it happened
        if (feat_count >= NUM_FEATURES) begin
          overflow_seen = 1'b1;
        end else begin
          if (model_loaded) begin
            for (c = 0; c < NUM_CLASSES; c++) begin
              score_acc[c] = sat32(longint'(score_acc[c]) +
                                   gauss_log_term(r.feature_value,
                                                  mean_tab[c][feat_count],
                                                  inv2var_tab[c][feat_count],
                                                  lognorm_tab[c][feat_count]));
            end
          end
          feat_count++;
        end
        // Close the sample: add priors, pick the first strictly best class
        if (r.last) begin
          verdict.predicted_class = '0;
          top_score = '0;
          if (model_loaded) begin
            for (c = 0; c < NUM_CLASSES; c++) begin
              s = sat32(longint'(score_acc[c]) + longint'(prior_tab[c]));
              if (c == 0 || s > top_score) begin
                top_score = s;
                verdict.predicted_class = CLS_W'(c);
              end
            end
          end
          verdict.best_score       = top_score;
          verdict.feature_overflow = overflow_seen;
          verdict.model_ready      = model_loaded;
          expected_verdicts.insert(expected_verdicts.size(), verdict);
          clear_sample();
        end
      end
      default: ;
    endcase
  endfunction

  // Check results first, then take in the request of the same edge
  always @(posedge clk) begin
    gnb_out_t want;
    gnb_out_t got;
    if (rst_n !== 1'b1) begin
      clear_sample();
      model_loaded = 1'b0;
      expected_verdicts.delete();
      n_mismatch = 0;
      n_checked  = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = out_mon.data;
        if (expected_verdicts.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_MAX)
            $display("%0t: unexpected result class %0d score %0d overflow %b ready %b",
                     $realtime, got.predicted_class, $signed(got.best_score),
                     got.feature_overflow, got.model_ready);
        end else begin
          want = expected_verdicts.pop_front();
          n_checked++;
          if (got.predicted_class !== want.predicted_class ||
              got.best_score !== want.best_score ||
              got.feature_overflow !== want.feature_overflow ||
              got.model_ready !== want.model_ready) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX)
              $display({"%0t: result %0d expected class %0d score %0d overflow %b ready %b,",
                        " got class %0d score %0d overflow %b ready %b"},
                       $realtime, n_checked,
                       want.predicted_class, $signed(want.best_score),
                       want.feature_overflow, want.model_ready,
                       got.predicted_class, $signed(got.best_score),
                       got.feature_overflow, got.model_ready);
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) absorb_request(in_mon.data);
    end
    mismatch_total   <= n_mismatch;
    verdicts_pending <= expected_verdicts.size();
    verdicts_checked <= n_checked;
  end

endmodule

// File: tb/tb_gaussian_naive_bayes_classifier_unit.sv
module tb_gaussian_naive_bayes_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gnb_pkg::*;

  localparam int NUM_FEATURES   = NUM_FEATURES_DEF;
  localparam int NUM_CLASSES    = NUM_CLASSES_DEF;
  localparam int REQUEST_TARGET = 2000;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 32;
  localparam int RESET_CYCLES   = 11;

  // Operation codes the block does not know
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  gnb_in_if  in_chan ();
  gnb_out_if out_chan ();

  int unsigned mismatch_total;
  int unsigned verdicts_pending;
  int unsigned verdicts_checked;

  int unsigned n_requests = 0;
  int unsigned n_loads = 0;
  int unsigned n_feature_items = 0;
  int unsigned n_samples = 0;
  int unsigned n_overflow_samples = 0;
  int unsigned n_ignored = 0;
  int unsigned cur_len = 0;
  int unsigned idle_cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  always #4ns clk = ~clk;

  gaussian_naive_bayes_classifier_unit #(
    .NUM_FEATURES (NUM_FEATURES),
    .NUM_CLASSES  (NUM_CLASSES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gnb_verdict_monitor #(
    .NUM_FEATURES (NUM_FEATURES),
    .NUM_CLASSES  (NUM_CLASSES)
  ) u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_chan),
    .out_mon          (out_chan),
    .mismatch_total   (mismatch_total),
    .verdicts_pending (verdicts_pending),
    .verdicts_checked (verdicts_checked)
  );

  function automatic int unsigned draw_pause(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Load request; the fields a load ignores carry random bits
  function automatic gnb_in_t load_req(logic [OP_W-1:0] op, logic [CLS_W-1:0] cls,
                                       logic [FEAT_W-1:0] feat, logic [COEF_W-1:0] coef);
    gnb_in_t r;
    r.operation     = op;
    r.class_index   = cls;
    r.feature_index = feat;
    r.coefficient   = coef;
    r.feature_value = X_W'($urandom);
    r.last          = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic gnb_in_t feature_req(logic [X_W-1:0] x, bit last);
    gnb_in_t r;
    r.operation     = OP_CLASSIFY;
    r.class_index   = CLS_W'($urandom_range(0, 3));
    r.feature_index = FEAT_W'($urandom_range(0, 15));
    r.coefficient   = $urandom;
    r.feature_value = x;
    r.last          = last;
    return r;
  endfunction

  // Mostly trained-model magnitudes, with the odd extreme or raw word
  function automatic logic [COEF_W-1:0] coef_draw(logic [OP_W-1:0] op);
    int unsigned       pick;
    logic [MEAN_W-1:0] low;
    int                realistic;
    pick = $urandom_range(0, 11);
    if (op == OP_LD_MEAN) begin
      case (pick)
        0:       low = 16'h7FFF;
        1:       low = 16'h8000;
        2:       low = 16'($urandom);
        default: low = 16'(int'($urandom_range(0, 2048)) - 1024);
      endcase
      return {16'($urandom), low};
    end
    case (op)
      OP_LD_INV2V: realistic = int'($urandom_range(0, 400000));
      OP_LD_LOGN:  realistic = int'($urandom_range(0, 262144)) - 196608;
      default:     realistic = -int'($urandom_range(0, 200000));
    endcase
    case (pick)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return realistic;
    endcase
  endfunction

  function automatic logic [X_W-1:0] sample_draw();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2560)) - 1280);
    endcase
  endfunction

  function automatic int unsigned sample_len_draw();
    case ($urandom_range(0, 7))
      0:       return NUM_FEATURES + $urandom_range(1, 4);
      1, 2:    return NUM_FEATURES;
      default: return $urandom_range(1, NUM_FEATURES);
    endcase
  endfunction

  // Request the block drops: unknown code or class out of range
  function automatic gnb_in_t noise_req();
    if ($urandom_range(0, 1))
      return load_req(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                      CLS_W'($urandom_range(0, 3)), FEAT_W'($urandom_range(0, 15)),
                      $urandom);
    return load_req(OP_W'($urandom_range(OP_LD_MEAN, OP_LD_PRIOR)),
                    CLS_W'($urandom_range(NUM_CLASSES, 3)),
                    FEAT_W'($urandom_range(0, 15)), $urandom);
  endfunction

  // Hold the request until accepted, then tally it
  task automatic push_request(gnb_in_t r);
    int unsigned pause;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    pause = draw_pause(in_calm);
    if (pause != 0) begin
      in_chan.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= r;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    n_requests++;
    if (r.operation == OP_CLASSIFY) begin
      n_feature_items++;
      cur_len++;
      if (r.last) begin
        n_samples++;
        if (cur_len > NUM_FEATURES) n_overflow_samples++;
        cur_len = 0;
      end
    end else if (r.operation > OP_LD_PRIOR || r.class_index >= NUM_CLASSES) begin
      n_ignored++;
    end else begin
      n_loads++;
    end
  endtask

  task automatic reload_random();
    logic [OP_W-1:0] op;
    op = OP_W'($urandom_range(OP_LD_MEAN, OP_LD_PRIOR));
    push_request(load_req(op, CLS_W'($urandom_range(0, NUM_CLASSES - 1)),
                          FEAT_W'($urandom_range(0, NUM_FEATURES - 1)), coef_draw(op)));
  endtask

  // Stream one sample, now and then slipping other requests between features
  task automatic run_sample(int unsigned len, bit mixed);
    for (int unsigned k = 1; k <= len; k++) begin
      if (mixed && $urandom_range(0, 9) == 0) push_request(noise_req());
      else if (mixed && $urandom_range(0, 19) == 0) reload_random();
      push_request(feature_req(sample_draw(), k == len));
    end
  endtask

  // Write every table entry so no classify reads an unwritten one
  task automatic fill_tables();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int f = 0; f < NUM_FEATURES; f++) begin
        push_request(load_req(OP_LD_MEAN, CLS_W'(c), FEAT_W'(f), coef_draw(OP_LD_MEAN)));
        push_request(load_req(OP_LD_INV2V, CLS_W'(c), FEAT_W'(f), coef_draw(OP_LD_INV2V)));
        push_request(load_req(OP_LD_LOGN, CLS_W'(c), FEAT_W'(f), coef_draw(OP_LD_LOGN)));
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++)
      push_request(load_req(OP_LD_PRIOR, CLS_W'(c), FEAT_W'($urandom_range(0, 15)),
                            coef_draw(OP_LD_PRIOR)));
  endtask

  // Give all classes the same first-feature model so their scores tie; now and then class 0 gets the lowest prior
  task automatic run_tie_sample();
    logic [COEF_W-1:0] mu;
    logic [COEF_W-1:0] v;
    logic [COEF_W-1:0] ln;
    logic [COEF_W-1:0] pr;
    bit                sink_first;
    mu = coef_draw(OP_LD_MEAN);
    v  = coef_draw(OP_LD_INV2V);
    ln = coef_draw(OP_LD_LOGN);
    pr = coef_draw(OP_LD_PRIOR);
    sink_first = ($urandom_range(0, 2) == 0);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      push_request(load_req(OP_LD_MEAN, CLS_W'(c), '0, mu));
      push_request(load_req(OP_LD_INV2V, CLS_W'(c), '0, v));
      push_request(load_req(OP_LD_LOGN, CLS_W'(c), '0, ln));
      push_request(load_req(OP_LD_PRIOR, CLS_W'(c), '0,
                            (c == 0 && sink_first) ? 32'h8000_0000 : pr));
    end
    push_request(feature_req(sample_draw(), 1'b1));
  endtask

  // Result side: random back-pressure with calm stretches
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = draw_pause(out_calm);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty model: a lone sample, dropped loads and codes, another lone sample, then an overlong sample
    push_request(feature_req(16'h8000, 1'b1));
    push_request(load_req(OP_LD_MEAN, CLS_W'(NUM_CLASSES), 4'hF, 32'h8000_0000));
    push_request(load_req(OP_LD_INV2V, CLS_W'(NUM_CLASSES), 4'h0, 32'h7FFF_FFFF));
    push_request(load_req(OP_LD_LOGN, CLS_W'(NUM_CLASSES), 4'hF, 32'hFFFF_FFFF));
    push_request(load_req(OP_LD_PRIOR, CLS_W'(NUM_CLASSES), 4'h0, 32'h0000_0000));
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      push_request(load_req(OP_W'(op), CLS_W'(op), FEAT_W'(op), $urandom));
    push_request(feature_req(16'h7FFF, 1'b1));
    run_sample(NUM_FEATURES + 1, 1'b0);

    // Loaded model: random samples, reloads, noise and forced ties
    fill_tables();
    while (n_requests < REQUEST_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) run_sample(sample_len_draw(), 1'b1);
      else if (pick < 16) repeat ($urandom_range(1, 6)) reload_random();
      else if (pick < 18) push_request(noise_req());
      else run_tie_sample();
    end
    in_chan.valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d table loads, %0d ignored, %0d features",
             n_requests, n_loads, n_ignored, n_feature_items);
    $display("%0d samples classified (%0d overlong), %0d results compared",
             n_samples, n_overflow_samples, verdicts_checked);
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gnb_pkg.sv
hdl/gnb_if.sv
hdl/gnb_ram.sv
hdl/gaussian_naive_bayes_classifier_unit.sv
tb/gnb_verdict_monitor.sv
tb/tb_gaussian_naive_bayes_classifier_unit.sv
